>>> design/gdcr_pkg.sv
package gdcr_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int MAP_SIDE      = 32;
    localparam int MAX_STEPS     = 64;

    localparam int MAP_BITS  = $clog2(MAP_SIDE);
    localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_BITS = 2 * MAP_BITS;
    localparam int STEP_BITS = $clog2(MAX_STEPS + 1);
    localparam int CRD_BITS  = MAP_BITS + 3;

    localparam int FRAC_BITS = 11;
    localparam int FRAC_ONE  = 1 << FRAC_BITS;
    localparam int CAM_BITS  = 12;
    localparam int NX_BITS   = 29;
    localparam int AX_BITS   = 28;
    localparam int FX_BITS   = 18;
    localparam int OPA_BITS  = 35;
    localparam int OPB_BITS  = 19;
    localparam int PROD_BITS = OPA_BITS + OPB_BITS;
    localparam int DIV_BITS  = 48;
    localparam int Q_BITS    = 11;
    localparam int C_BITS    = 20;
    localparam int DNUM_BITS = 32;
    localparam int BD_BITS   = 34;
    localparam int ROW_BITS  = 9;

    localparam int HALF_H       = SCREEN_HEIGHT / 2;
    localparam int LH_MAX       = 2 * SCREEN_HEIGHT + 2;
    localparam int SHADE_X      = 2550;
    localparam int SHADE_Y      = 1785;
    localparam int BLUE_FLOOR_X = 25;
    localparam int BLUE_FLOOR_Y = 17;
    localparam int LH_DIV_ITERS = Q_BITS;
    localparam int BL_DIV_ITERS = 8;

    typedef enum logic [2:0] {
        CFG_POS_X   = 3'd0,
        CFG_POS_Y   = 3'd1,
        CFG_DIR_X   = 3'd2,
        CFG_DIR_Y   = 3'd3,
        CFG_PLANE_X = 3'd4,
        CFG_PLANE_Y = 3'd5,
        CFG_FADE    = 3'd6
    } cfg_idx_t;

    typedef enum logic [15:0] {
        S_CLEAR = 16'b0000_0000_0000_0001,
        S_IDLE  = 16'b0000_0000_0000_0010,
        S_RAYX  = 16'b0000_0000_0000_0100,
        S_RAYY  = 16'b0000_0000_0000_1000,
        S_INIT  = 16'b0000_0000_0001_0000,
        S_MULA  = 16'b0000_0000_0010_0000,
        S_MULB  = 16'b0000_0000_0100_0000,
        S_STEP  = 16'b0000_0000_1000_0000,
        S_READ  = 16'b0000_0001_0000_0000,
        S_CHECK = 16'b0000_0010_0000_0000,
        S_DIST  = 16'b0000_0100_0000_0000,
        S_LHSET = 16'b0000_1000_0000_0000,
        S_BSET  = 16'b0001_0000_0000_0000,
        S_BMUL  = 16'b0010_0000_0000_0000,
        S_DIV   = 16'b0100_0000_0000_0000,
        S_FIN   = 16'b1000_0000_0000_0000
    } state_t;

endpackage

>>> design/grid_dda_column_raycaster.sv
// Column ray caster over a 32 x 32 wall map, stepping the ray with DDA.
// Command channel (cmd_valid/cmd_ready): action 0 writes one map cell;
// action 1 casts the ray of one screen column and yields exactly one item
// on the result channel (res_valid/res_ready).
// Configuration is written through cfg_we/cfg_index/cfg_data while idle,
// a rule on the user that the block does not enforce. After reset the map
// is cleared by a pass over all 1024 cells, one cell a cycle; cmd_ready
// stays low during that pass, configuration writes are taken at any time.
// A cast runs the setup states RAYX, RAYY and INIT, then per DDA step MULA,
// MULB, STEP, READ and CHECK (two products on the shared multiplier, the
// step, the map read and the hit check). On a hit follow the distance, the
// span division and the blue division, either division skipped when its
// result is fixed in advance, and the final state hands the item to the
// output register. A miss at the limit of 64 steps goes to FIN directly.
// One multiplier and one restoring divider do all products and divisions;
// the sequencer walks one item at a time, and cmd_ready is high only when idle.
// Results wait in an output register; if the receiver stalls, a finished
// cast holds in the final state until the register frees up, so at most
// one result and one cast in progress exist at once.
module grid_dda_column_raycaster
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic        action,
    input  logic [9:0]  column,
    input  logic [4:0]  cell_x,
    input  logic [4:0]  cell_y,
    input  logic        cell_wall,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [9:0]  out_column,
    output logic [8:0]  draw_start,
    output logic [8:0]  draw_end,
    output logic        hit_side,
    output logic [7:0]  blue_level,
    output logic [4:0]  hit_cell_x,
    output logic [4:0]  hit_cell_y,
    output logic        hit_found
);

    localparam int AB = gdcr_pkg::ADDR_BITS;
    localparam int CB = gdcr_pkg::CRD_BITS;
    localparam int MB = gdcr_pkg::MAP_BITS;
    localparam int DB = gdcr_pkg::DIV_BITS;
    localparam int QB = gdcr_pkg::Q_BITS;

    // Configuration registers.
    logic [15:0]        pos_x_reg, pos_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [5:0]         fade_reg;

    // Sequencer and ray state.
    gdcr_pkg::state_t state_reg;
    logic [AB-1:0]                       clr_cnt_reg;
    logic [9:0]                          col_reg;
    logic signed [gdcr_pkg::CAM_BITS-1:0] cam_reg;
    logic signed [gdcr_pkg::NX_BITS-1:0]  nx_reg;
    logic [gdcr_pkg::AX_BITS-1:0]        ax_reg, ay_reg;
    logic [gdcr_pkg::FX_BITS-1:0]        fx_reg, fy_reg;
    logic signed [CB-1:0]                mx_reg, my_reg;
    logic                                sxn_reg, syn_reg, side_reg, hit_reg, inf_reg;
    logic [gdcr_pkg::STEP_BITS-1:0]      steps_reg;
    logic signed [gdcr_pkg::PROD_BITS-1:0] prod_reg, pa_reg;
    logic [gdcr_pkg::DNUM_BITS-1:0]      dnum_reg;
    logic [gdcr_pkg::AX_BITS-1:0]        dden_reg;
    logic [gdcr_pkg::BD_BITS-1:0]        bd_reg;
    logic [DB-1:0]                       rem_reg, dvs_reg;
    logic [QB-1:0]                       q_reg;
    logic [3:0]                          cnt_reg;
    logic                                div_blue_reg;
    logic [8:0]                          ds_reg, de_reg;

    // Output register.
    logic       res_valid_reg;
    logic       res_load;
    logic [9:0] out_column_reg;
    logic [8:0] draw_start_reg, draw_end_reg;
    logic       hit_side_reg, hit_found_reg;
    logic [7:0] blue_level_reg;
    logic [4:0] hit_cell_x_reg, hit_cell_y_reg;

    // Wall map.
    logic          wall_mem [gdcr_pkg::MAP_DEPTH];
    logic          rd_reg;
    logic          mem_we;
    logic [AB-1:0] mem_waddr, mem_raddr;
    logic          mem_wdata;

    // Shared multiplier.
    logic signed [gdcr_pkg::OPA_BITS-1:0]  op_a;
    logic signed [gdcr_pkg::OPB_BITS-1:0]  op_b;
    logic signed [gdcr_pkg::PROD_BITS-1:0] prod;

    // Combinational helpers.
    logic signed [gdcr_pkg::NX_BITS-1:0] dx_ext, dy_ext, dx640, dy640, ny;
    logic signed [gdcr_pkg::C_BITS-1:0]  c_val;
    logic [gdcr_pkg::C_BITS-2:0]         c_abs;
    logic [gdcr_pkg::AX_BITS-1:0]        dden_sel;
    logic [DB-1:0]                       lh_num, lh_big;
    logic [QB-1:0]                       lh_clamp;
    logic [QB-2:0]                       lh_half;
    logic [39:0]                         dnum_x10, bd_x9;
    logic [gdcr_pkg::BD_BITS-1:0]        bn;
    logic                                floor_it, outside, step_x, div_ge;

    assign cmd_ready = (state_reg == gdcr_pkg::S_IDLE);

    // A finished cast moves into the output register when it is free or
    // being emptied in the same cycle.
    assign res_load = (state_reg == gdcr_pkg::S_FIN) && (!res_valid_reg || res_ready);

    assign dx_ext = gdcr_pkg::NX_BITS'(dir_x_reg);
    assign dy_ext = gdcr_pkg::NX_BITS'(dir_y_reg);
    assign dx640  = (dx_ext <<< 9) + (dx_ext <<< 7);
    assign dy640  = (dy_ext <<< 9) + (dy_ext <<< 7);
    assign ny     = dy640 + prod_reg[gdcr_pkg::NX_BITS-1:0];

    assign dden_sel = side_reg ? ay_reg : ax_reg;
    assign bn       = bd_reg - gdcr_pkg::BD_BITS'(dnum_reg);
    assign step_x   = (pa_reg < prod_reg);
    assign outside  = mx_reg[CB-1] || my_reg[CB-1]
                   || (mx_reg >= $signed(CB'(gdcr_pkg::MAP_SIDE)))
                   || (my_reg >= $signed(CB'(gdcr_pkg::MAP_SIDE)));

    // Distance numerator along the crossed axis, in Q11 cells.
    always_comb
    begin
        if (side_reg)
        begin
            c_val = (gdcr_pkg::C_BITS'(my_reg) <<< gdcr_pkg::FRAC_BITS)
                  - $signed({4'd0, pos_y_reg})
                  + (syn_reg ? gdcr_pkg::C_BITS'(gdcr_pkg::FRAC_ONE) : '0);
        end
        else
        begin
            c_val = (gdcr_pkg::C_BITS'(mx_reg) <<< gdcr_pkg::FRAC_BITS)
                  - $signed({4'd0, pos_x_reg})
                  + (sxn_reg ? gdcr_pkg::C_BITS'(gdcr_pkg::FRAC_ONE) : '0);
        end
        c_abs = c_val[gdcr_pkg::C_BITS-1] ? (gdcr_pkg::C_BITS-1)'(-c_val)
                                          : c_val[gdcr_pkg::C_BITS-2:0];
    end

    assign lh_num   = (DB'(dden_reg) << 9) - (DB'(dden_reg) << 5);
    assign lh_big   = DB'(dnum_reg) << QB;
    assign lh_clamp = (q_reg > QB'(gdcr_pkg::LH_MAX)) ? QB'(gdcr_pkg::LH_MAX) : q_reg;
    assign lh_half  = lh_clamp[QB-1:1];
    assign dnum_x10 = (40'(dnum_reg) << 3) + (40'(dnum_reg) << 1);
    assign bd_x9    = (40'(bd_reg) << 3) + 40'(bd_reg);
    assign floor_it = inf_reg || (fade_reg == 6'd0) || (dnum_x10 >= bd_x9);
    assign div_ge   = (rem_reg >= dvs_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            gdcr_pkg::S_RAYX:
            begin
                op_a = gdcr_pkg::OPA_BITS'(plane_x_reg);
                op_b = gdcr_pkg::OPB_BITS'(cam_reg);
            end
            gdcr_pkg::S_RAYY:
            begin
                op_a = gdcr_pkg::OPA_BITS'(plane_y_reg);
                op_b = gdcr_pkg::OPB_BITS'(cam_reg);
            end
            gdcr_pkg::S_MULA:
            begin
                op_a = $signed({7'd0, ay_reg});
                op_b = $signed({1'b0, fx_reg});
            end
            gdcr_pkg::S_MULB:
            begin
                op_a = $signed({7'd0, ax_reg});
                op_b = $signed({1'b0, fy_reg});
            end
            gdcr_pkg::S_DIST:
            begin
                op_a = $signed({7'd0, dden_sel});
                op_b = $signed({13'd0, fade_reg});
            end
            gdcr_pkg::S_BSET:
            begin
                op_a = $signed({1'b0, bn});
                op_b = side_reg ? gdcr_pkg::OPB_BITS'(gdcr_pkg::SHADE_Y)
                                : gdcr_pkg::OPB_BITS'(gdcr_pkg::SHADE_X);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // Map write and read ports.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 1'b0;
        if (state_reg == gdcr_pkg::S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (cmd_ready && cmd_valid && !action)
        begin
            mem_we    = 1'b1;
            mem_waddr = {cell_y, cell_x};
            mem_wdata = cell_wall;
        end
    end

    assign mem_raddr = {my_reg[MB-1:0], mx_reg[MB-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wall_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= wall_mem[mem_raddr];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= -16'sd16384;
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= 16'sd10813;
            fade_reg    <= 6'd30;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gdcr_pkg::CFG_POS_X:   pos_x_reg   <= cfg_data;
                gdcr_pkg::CFG_POS_Y:   pos_y_reg   <= cfg_data;
                gdcr_pkg::CFG_DIR_X:   dir_x_reg   <= $signed(cfg_data);
                gdcr_pkg::CFG_DIR_Y:   dir_y_reg   <= $signed(cfg_data);
                gdcr_pkg::CFG_PLANE_X: plane_x_reg <= $signed(cfg_data);
                gdcr_pkg::CFG_PLANE_Y: plane_y_reg <= $signed(cfg_data);
                gdcr_pkg::CFG_FADE:    fade_reg    <= cfg_data[5:0];
                default:               ;
            endcase
        end
    end

    // Sequencer and datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gdcr_pkg::S_CLEAR;
            clr_cnt_reg    <= '0;
            res_valid_reg  <= 1'b0;
            col_reg        <= '0;
            cam_reg        <= '0;
            nx_reg         <= '0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            fx_reg         <= '0;
            fy_reg         <= '0;
            mx_reg         <= '0;
            my_reg         <= '0;
            sxn_reg        <= 1'b0;
            syn_reg        <= 1'b0;
            side_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            inf_reg        <= 1'b0;
            steps_reg      <= '0;
            prod_reg       <= '0;
            pa_reg         <= '0;
            dnum_reg       <= '0;
            dden_reg       <= '0;
            bd_reg         <= '0;
            rem_reg        <= '0;
            dvs_reg        <= '0;
            q_reg          <= '0;
            cnt_reg        <= '0;
            div_blue_reg   <= 1'b0;
            ds_reg         <= '0;
            de_reg         <= '0;
            out_column_reg <= '0;
            draw_start_reg <= '0;
            draw_end_reg   <= '0;
            hit_side_reg   <= 1'b0;
            blue_level_reg <= '0;
            hit_cell_x_reg <= '0;
            hit_cell_y_reg <= '0;
            hit_found_reg  <= 1'b0;
        end
        else
        begin
            prod_reg <= prod;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                gdcr_pkg::S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AB'(gdcr_pkg::MAP_DEPTH - 1))
                    begin
                        state_reg <= gdcr_pkg::S_IDLE;
                    end
                end
                gdcr_pkg::S_IDLE:
                begin
                    if (cmd_valid && action)
                    begin
                        col_reg   <= column;
                        cam_reg   <= $signed({1'b0, column, 1'b0})
                                   - gdcr_pkg::CAM_BITS'(gdcr_pkg::SCREEN_WIDTH);
                        state_reg <= gdcr_pkg::S_RAYX;
                    end
                end
                gdcr_pkg::S_RAYX:
                begin
                    state_reg <= gdcr_pkg::S_RAYY;
                end
                gdcr_pkg::S_RAYY:
                begin
                    nx_reg    <= dx640 + prod_reg[gdcr_pkg::NX_BITS-1:0];
                    state_reg <= gdcr_pkg::S_INIT;
                end
                gdcr_pkg::S_INIT:
                begin
                    ax_reg  <= nx_reg[gdcr_pkg::NX_BITS-1]
                             ? gdcr_pkg::AX_BITS'(-nx_reg) : nx_reg[gdcr_pkg::AX_BITS-1:0];
                    ay_reg  <= ny[gdcr_pkg::NX_BITS-1]
                             ? gdcr_pkg::AX_BITS'(-ny) : ny[gdcr_pkg::AX_BITS-1:0];
                    sxn_reg <= nx_reg[gdcr_pkg::NX_BITS-1];
                    syn_reg <= ny[gdcr_pkg::NX_BITS-1];
                    fx_reg  <= nx_reg[gdcr_pkg::NX_BITS-1]
                             ? gdcr_pkg::FX_BITS'(pos_x_reg[10:0])
                             : gdcr_pkg::FX_BITS'(gdcr_pkg::FRAC_ONE)
                               - gdcr_pkg::FX_BITS'(pos_x_reg[10:0]);
                    fy_reg  <= ny[gdcr_pkg::NX_BITS-1]
                             ? gdcr_pkg::FX_BITS'(pos_y_reg[10:0])
                             : gdcr_pkg::FX_BITS'(gdcr_pkg::FRAC_ONE)
                               - gdcr_pkg::FX_BITS'(pos_y_reg[10:0]);
                    mx_reg    <= $signed(CB'(pos_x_reg[15:11]));
                    my_reg    <= $signed(CB'(pos_y_reg[15:11]));
                    steps_reg <= '0;
                    side_reg  <= 1'b0;
                    state_reg <= gdcr_pkg::S_MULA;
                end
                gdcr_pkg::S_MULA:
                begin
                    state_reg <= gdcr_pkg::S_MULB;
                end
                gdcr_pkg::S_MULB:
                begin
                    pa_reg    <= prod_reg;
                    state_reg <= gdcr_pkg::S_STEP;
                end
                gdcr_pkg::S_STEP:
                begin
                    // pa_reg holds fx*ay, prod_reg holds fy*ax.
                    if (step_x)
                    begin
                        fx_reg   <= fx_reg + gdcr_pkg::FX_BITS'(gdcr_pkg::FRAC_ONE);
                        mx_reg   <= sxn_reg ? mx_reg - 1'b1 : mx_reg + 1'b1;
                        side_reg <= 1'b0;
                    end
                    else
                    begin
                        fy_reg   <= fy_reg + gdcr_pkg::FX_BITS'(gdcr_pkg::FRAC_ONE);
                        my_reg   <= syn_reg ? my_reg - 1'b1 : my_reg + 1'b1;
                        side_reg <= 1'b1;
                    end
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= gdcr_pkg::S_READ;
                end
                gdcr_pkg::S_READ:
                begin
                    state_reg <= gdcr_pkg::S_CHECK;
                end
                gdcr_pkg::S_CHECK:
                begin
                    priority if (outside || rd_reg)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= gdcr_pkg::S_DIST;
                    end
                    else if (steps_reg == gdcr_pkg::STEP_BITS'(gdcr_pkg::MAX_STEPS))
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= gdcr_pkg::S_FIN;
                    end
                    else
                    begin
                        state_reg <= gdcr_pkg::S_MULA;
                    end
                end
                gdcr_pkg::S_DIST:
                begin
                    dnum_reg  <= (gdcr_pkg::DNUM_BITS'(c_abs) << 12)
                               + (gdcr_pkg::DNUM_BITS'(c_abs) << 10);
                    dden_reg  <= dden_sel;
                    inf_reg   <= (dden_sel == '0);
                    state_reg <= gdcr_pkg::S_LHSET;
                end
                gdcr_pkg::S_LHSET:
                begin
                    bd_reg <= prod_reg[gdcr_pkg::BD_BITS-1:0];
                    priority if (inf_reg)
                    begin
                        q_reg     <= '0;
                        state_reg <= gdcr_pkg::S_BSET;
                    end
                    else if ((dnum_reg == '0) || (lh_num >= lh_big))
                    begin
                        q_reg     <= QB'(gdcr_pkg::LH_MAX);
                        state_reg <= gdcr_pkg::S_BSET;
                    end
                    else
                    begin
                        rem_reg      <= lh_num;
                        dvs_reg      <= DB'(dnum_reg) << (QB - 1);
                        q_reg        <= '0;
                        cnt_reg      <= 4'(gdcr_pkg::LH_DIV_ITERS);
                        div_blue_reg <= 1'b0;
                        state_reg    <= gdcr_pkg::S_DIV;
                    end
                end
                gdcr_pkg::S_BSET:
                begin
                    ds_reg <= (lh_half > (QB-1)'(gdcr_pkg::HALF_H)) ? 9'd0
                            : 9'(gdcr_pkg::HALF_H) - 9'(lh_half);
                    de_reg <= (10'(lh_half) + 10'(gdcr_pkg::HALF_H)
                               >= 10'(gdcr_pkg::SCREEN_HEIGHT))
                            ? 9'(gdcr_pkg::SCREEN_HEIGHT - 1)
                            : 9'(10'(lh_half) + 10'(gdcr_pkg::HALF_H));
                    if (floor_it)
                    begin
                        q_reg     <= side_reg ? QB'(gdcr_pkg::BLUE_FLOOR_Y)
                                              : QB'(gdcr_pkg::BLUE_FLOOR_X);
                        state_reg <= gdcr_pkg::S_FIN;
                    end
                    else
                    begin
                        state_reg <= gdcr_pkg::S_BMUL;
                    end
                end
                gdcr_pkg::S_BMUL:
                begin
                    // prod_reg holds 255 * shade * (bd - dnum); divide by bd * 10.
                    rem_reg      <= prod_reg[DB-1:0];
                    dvs_reg      <= ((DB'(bd_reg) << 3) + (DB'(bd_reg) << 1))
                                    << (gdcr_pkg::BL_DIV_ITERS - 1);
                    q_reg        <= '0;
                    cnt_reg      <= 4'(gdcr_pkg::BL_DIV_ITERS);
                    div_blue_reg <= 1'b1;
                    state_reg    <= gdcr_pkg::S_DIV;
                end
                gdcr_pkg::S_DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - dvs_reg;
                    end
                    q_reg   <= {q_reg[QB-2:0], div_ge};
                    dvs_reg <= dvs_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 4'd1)
                    begin
                        state_reg <= div_blue_reg ? gdcr_pkg::S_FIN : gdcr_pkg::S_BSET;
                    end
                end
                gdcr_pkg::S_FIN:
                begin
                    if (res_load)
                    begin
                        out_column_reg <= col_reg;
                        draw_start_reg <= hit_reg ? ds_reg : '0;
                        draw_end_reg   <= hit_reg ? de_reg : '0;
                        hit_side_reg   <= hit_reg & side_reg;
                        blue_level_reg <= hit_reg ? q_reg[7:0] : '0;
                        hit_cell_x_reg <= hit_reg ? mx_reg[MB-1:0] : '0;
                        hit_cell_y_reg <= hit_reg ? my_reg[MB-1:0] : '0;
                        hit_found_reg  <= hit_reg;
                        state_reg      <= gdcr_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= gdcr_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_column = out_column_reg;
    assign draw_start = draw_start_reg;
    assign draw_end   = draw_end_reg;
    assign hit_side   = hit_side_reg;
    assign blue_level = blue_level_reg;
    assign hit_cell_x = hit_cell_x_reg;
    assign hit_cell_y = hit_cell_y_reg;
    assign hit_found  = hit_found_reg;

    // The sequencer is always in exactly one state.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // The walk never runs past the step limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= gdcr_pkg::STEP_BITS'(gdcr_pkg::MAX_STEPS))
        else $error("step count beyond limit");

    // A reported wall span is ordered and lies on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && hit_found_reg |->
            (draw_start_reg <= draw_end_reg)
            && (draw_end_reg < 9'(gdcr_pkg::SCREEN_HEIGHT)))
        else $error("wall span out of order or off screen");

    // A missed ray reports no shading.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !hit_found_reg |-> (blue_level_reg == 8'd0) && !hit_side_reg)
        else $error("missed ray carries hit data");

    // A finished cast leaves for the output register as soon as it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gdcr_pkg::S_FIN) && !res_valid_reg |=> res_valid_reg)
        else $error("finished cast not delivered");

endmodule

>>> sim/grid_dda_column_raycaster_checker.sv
`timescale 1ns / 100ps

module grid_dda_column_raycaster_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  logic        action,
    input  logic [9:0]  column,
    input  logic [4:0]  cell_x,
    input  logic [4:0]  cell_y,
    input  logic        cell_wall,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [9:0]  out_column,
    input  logic [8:0]  draw_start,
    input  logic [8:0]  draw_end,
    input  logic        hit_side,
    input  logic [7:0]  blue_level,
    input  logic [4:0]  hit_cell_x,
    input  logic [4:0]  hit_cell_y,
    input  logic        hit_found,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [9:0] col;
        logic [8:0] top_row;
        logic [8:0] bot_row;
        logic       side;
        logic [7:0] blue;
        logic [4:0] hx;
        logic [4:0] hy;
        logic       found;
    } span_t;

    logic        walls [gdcr_pkg::MAP_DEPTH];
    logic [15:0] view_px, view_py;
    logic signed [15:0] view_dx, view_dy, view_plx, view_ply;
    logic [5:0]  fade;
    span_t       span_q [$];

    function automatic logic wall_at(longint x, longint y);
        if (x < 0 || y < 0 || x >= gdcr_pkg::MAP_SIDE || y >= gdcr_pkg::MAP_SIDE)
            return 1'b1;
        return walls[y * gdcr_pkg::MAP_SIDE + x];
    endfunction

    function automatic longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Walks one column ray through the map and forms its wall span and shade.
    function automatic span_t cast_column(logic [9:0] col);
        span_t  r;
        longint cam, nx, ny, ax, ay, fx, fy, mx, my, sx, sy;
        longint c, n, dnum, dden, lh, ds, de, bn, bd, shade;
        int     side, steps;
        logic   hit, inf, dim;
        r = '0;
        r.col = col;
        side = 0;
        hit = 0;
        inf = 0;
        dnum = 0;
        dden = 0;
        cam = 2 * longint'(col) - gdcr_pkg::SCREEN_WIDTH;
        nx = longint'(view_dx) * gdcr_pkg::SCREEN_WIDTH + longint'(view_plx) * cam;
        ny = longint'(view_dy) * gdcr_pkg::SCREEN_WIDTH + longint'(view_ply) * cam;
        ax = absval(nx);
        ay = absval(ny);
        mx = longint'(view_px >> gdcr_pkg::FRAC_BITS);
        my = longint'(view_py >> gdcr_pkg::FRAC_BITS);
        if (nx < 0)
        begin
            sx = -1;
            fx = view_px & 16'h07FF;
        end
        else
        begin
            sx = 1;
            fx = gdcr_pkg::FRAC_ONE - (view_px & 16'h07FF);
        end
        if (ny < 0)
        begin
            sy = -1;
            fy = view_py & 16'h07FF;
        end
        else
        begin
            sy = 1;
            fy = gdcr_pkg::FRAC_ONE - (view_py & 16'h07FF);
        end
        for (steps = 0; steps < gdcr_pkg::MAX_STEPS && !hit; steps++)
        begin
            if (fx * ay < fy * ax)
            begin
                fx += gdcr_pkg::FRAC_ONE;
                mx += sx;
                side = 0;
            end
            else
            begin
                fy += gdcr_pkg::FRAC_ONE;
                my += sy;
                side = 1;
            end
            hit = wall_at(mx, my);
        end
        if (!hit)
            return r;
        if (side == 0)
        begin
            c = mx * gdcr_pkg::FRAC_ONE - longint'(view_px)
              + ((sx < 0) ? gdcr_pkg::FRAC_ONE : 0);
            n = ax;
        end
        else
        begin
            c = my * gdcr_pkg::FRAC_ONE - longint'(view_py)
              + ((sy < 0) ? gdcr_pkg::FRAC_ONE : 0);
            n = ay;
        end
        if (n == 0)
            inf = 1;
        else
        begin
            dnum = absval(c) * gdcr_pkg::SCREEN_WIDTH * 8;
            dden = n;
        end
        if (inf)
            lh = 0;
        else if (dnum == 0)
            lh = gdcr_pkg::LH_MAX;
        else
        begin
            lh = longint'(gdcr_pkg::SCREEN_HEIGHT) * dden / dnum;
            if (lh > gdcr_pkg::LH_MAX)
                lh = gdcr_pkg::LH_MAX;
        end
        ds = gdcr_pkg::HALF_H - lh / 2;
        de = gdcr_pkg::HALF_H + lh / 2;
        if (ds < 0)
            ds = 0;
        if (de >= gdcr_pkg::SCREEN_HEIGHT)
            de = gdcr_pkg::SCREEN_HEIGHT - 1;
        // Brightness is bn/bd; past nine tenths of the fade it sits at the floor.
        shade = side ? 7 : 10;
        dim = inf || fade == 0;
        bn = 0;
        bd = 1;
        if (!dim)
        begin
            bd = longint'(fade) * dden;
            if (dnum * 10 >= bd * 9)
                dim = 1;
            else
                bn = bd - dnum;
        end
        if (dim)
            r.blue = 8'(255 * shade / 100);
        else
            r.blue = 8'(255 * bn * shade / (bd * 10));
        r.top_row = 9'(ds);
        r.bot_row = 9'(de);
        r.side = 1'(side);
        r.hx = 5'(mx);
        r.hy = 5'(my);
        r.found = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        span_t got, want;
        if (!rst_n)
        begin
            foreach (walls[i])
                walls[i] = 1'b0;
            view_px = 16'd0;
            view_py = 16'd0;
            view_dx = -16'sd16384;
            view_dy = 16'sd0;
            view_plx = 16'sd0;
            view_ply = 16'sd10813;
            fade = 6'd30;
            span_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (gdcr_pkg::cfg_idx_t'(cfg_index))
                    gdcr_pkg::CFG_POS_X:   view_px = cfg_data;
                    gdcr_pkg::CFG_POS_Y:   view_py = cfg_data;
                    gdcr_pkg::CFG_DIR_X:   view_dx = cfg_data;
                    gdcr_pkg::CFG_DIR_Y:   view_dy = cfg_data;
                    gdcr_pkg::CFG_PLANE_X: view_plx = cfg_data;
                    gdcr_pkg::CFG_PLANE_Y: view_ply = cfg_data;
                    gdcr_pkg::CFG_FADE:    fade = cfg_data[5:0];
                    default:               ;
                endcase
            end
            if (res_valid && res_ready)
            begin
                got = {out_column, draw_start, draw_end, hit_side, blue_level,
                       hit_cell_x, hit_cell_y, hit_found};
                if (span_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result item: %p", got);
                end
                else
                begin
                    want = span_q.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at %0t: expected %p actual %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                if (action)
                    span_q.push_back(cast_column(column));
                else
                    walls[cell_y * gdcr_pkg::MAP_SIDE + cell_x] = cell_wall;
            end
            pending = span_q.size();
        end
    end

endmodule

>>> sim/tb_grid_dda_column_raycaster.sv
`timescale 1ns / 100ps

module tb_grid_dda_column_raycaster;

    // The run ends as a failure past this many cycles.
    localparam int CYCLE_LIMIT = 4000000;
    // Tail waited at the end of a drain, after the last cast has reported.
    localparam int DRAIN_CYCLES = 500;
    localparam int HOLD_CYCLES = 3000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        cmd_valid;
    logic        cmd_ready;
    logic        action;
    logic [9:0]  column;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic        cell_wall;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [9:0]  out_column;
    logic [8:0]  draw_start;
    logic [8:0]  draw_end;
    logic        hit_side;
    logic [7:0]  blue_level;
    logic [4:0]  hit_cell_x;
    logic [4:0]  hit_cell_y;
    logic        hit_found;
    int          errors;
    int          pending;

    // Set by the stimulus to remove idling on both sides for a stretch.
    logic        quiet;
    // Set by the stimulus to ask the receiver for one long hold-off.
    logic        hold_req;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          cycles = 0;

    grid_dda_column_raycaster uut (.*);

    grid_dda_column_raycaster_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver idles at random, 36 times in a hundred. Once asked, it holds
    // off for a long stretch while the sender keeps offering items, so the
    // output register and the cast in flight fill up and cmd_ready drops.
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end
        else if (quiet)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offers one item and returns after the edge that accepts it. Valid is
    // left high, so a following item goes out back to back unless the
    // random gap below lowers it.
    task automatic offer_item(input logic act, input logic [9:0] col,
                              input logic [4:0] cx, input logic [4:0] cy,
                              input logic wall);
        int gap;
        cmd_valid <= 1'b1;
        action    <= act;
        column    <= col;
        cell_x    <= cx;
        cell_y    <= cy;
        cell_wall <= wall;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        if (!quiet && $urandom_range(99) < 36)
        begin
            gap = $urandom_range(4, 1);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic cast_ray(input logic [9:0] col);
        offer_item(1'b1, col, 5'($urandom), 5'($urandom), 1'($urandom));
    endtask

    task automatic put_cell(input logic [4:0] cx, input logic [4:0] cy,
                            input logic wall);
        offer_item(1'b0, 10'($urandom), cx, cy, wall);
    endtask

    // Waits until every cast has reported, then lets a possible trailing
    // cell write settle before registers change.
    task automatic drain;
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all seven registers on consecutive edges, then drops the enable.
    task automatic load_view(input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] dx, input logic [15:0] dy,
                             input logic [15:0] plx, input logic [15:0] ply,
                             input logic [15:0] fd);
        logic [15:0] vals [7];
        vals = '{px, py, dx, dy, plx, ply, fd};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Direction and plane components: half the time ordinary, else an extreme,
    // zero or a tiny value, so that axis-aligned rays appear as well.
    function automatic logic [15:0] pick_vec;
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = gdcr_pkg::CFG_POS_X;
        cfg_data  = 16'd0;
        cmd_valid = 1'b0;
        action    = 1'b0;
        column    = 10'd0;
        cell_x    = 5'd0;
        cell_y    = 5'd0;
        cell_wall = 1'b0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. With the reset view the viewer stands on the map
        // corner looking toward -x, so the first casts hit the border at zero
        // distance and the span covers the whole column.
        cast_ray(10'd0);
        cast_ray(10'd320);
        cast_ray(10'd639);
        cast_ray(10'd640);
        cast_ray(10'd1023);
        put_cell(5'd0, 5'd0, 1'b1);
        put_cell(5'd31, 5'd31, 1'b1);
        put_cell(5'd31, 5'd0, 1'b1);
        put_cell(5'd0, 5'd0, 1'b0);
        drain();
        // From the map center, casting across the screen.
        load_view(16'h8400, 16'h8400, 16'hC000, 16'h0000, 16'h0000, 16'h2A3D, 16'd1);
        cast_ray(10'd0);
        cast_ray(10'd319);
        cast_ray(10'd639);
        put_cell(5'd12, 5'd16, 1'b1);
        cast_ray(10'd320);
        drain();
        // Both ray components zero: infinite distance and floor brightness.
        load_view(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd63);
        cast_ray(10'd5);
        drain();
        // One component zero, extreme direction, fade switched off.
        load_view(16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'd0);
        cast_ray(10'd320);
        cast_ray(10'd0);
        cast_ray(10'd1023);
        drain();
        // A diagonal ray from the map corner across the mostly open map.
        load_view(16'h0400, 16'h0400, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'd30);
        cast_ray(10'd100);
        drain();

        // Random phases: each sets a new view, then mixes cell writes and
        // casts. Phase 2 runs with no idling; phase 4 asks for the hold-off.
        for (int ph = 0; ph < 8; ph++)
        begin
            load_view(16'($urandom), 16'($urandom), pick_vec(), pick_vec(),
                      pick_vec(), pick_vec(), 16'($urandom_range(63)));
            quiet = (ph == 2);
            if (ph == 4)
                hold_req = 1'b1;
            for (int k = 0; k < 235; k++)
            begin
                if ($urandom_range(99) < 30)
                    put_cell(5'($urandom), 5'($urandom), $urandom_range(99) < 35);
                else if ($urandom_range(9) == 0)
                    cast_ray(10'($urandom));
                else
                    cast_ray(10'($urandom_range(639)));
            end
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
design/gdcr_pkg.sv
design/grid_dda_column_raycaster.sv
sim/grid_dda_column_raycaster_checker.sv
sim/tb_grid_dda_column_raycaster.sv
